### rtl/csq_pkg.sv
// Package for the counting semaphore wait queue: codes, entry and command types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

    // Number of waiter cells in the chain
    localparam int WAITERS = 16;

    localparam int COUNT_W     = 16;
    localparam int TASK_W      = 4;
    localparam int CLASS_W     = 2;
    localparam int PRIO_W      = 8;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_WAIT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POST    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    // Waiter classes
    localparam logic [CLASS_W-1:0] CLS_FIFO   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_RT     = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_NORMAL = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RAISED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd6;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT     = 2'd1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    // Contents of one waiter cell
    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [CLASS_W-1:0] cls;
        logic [PRIO_W-1:0]  prio;
        logic               timed;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        logic     head_only;
        entry_t   item;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/csq_cell.sv
// One waiter cell: holds an entry and decides locally whether to hold, load,
// shift in from its left neighbour or from its right neighbour. Uses csq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csq_pkg::cell_cmd_t cmd,
    input  wire logic              prev_valid,
    input  wire csq_pkg::entry_t   prev_entry,
    input  wire logic              prev_keep,
    input  wire logic              next_valid,
    input  wire csq_pkg::entry_t   next_entry,
    input  wire logic              found_in,
    output logic                   valid,
    output csq_pkg::entry_t        entry,
    output logic                   keep,
    output logic                   found_out
);
    import csq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   ahead;
    logic   match;

    // Does the stored waiter stay ahead of the one being inserted
    always_comb
    begin
        case (cmd.item.cls)
            CLS_FIFO:
            begin
                ahead = (entry_reg.cls == CLS_FIFO);
            end
            CLS_RT:
            begin
                ahead = (entry_reg.cls == CLS_FIFO) ||
                        ((entry_reg.cls == CLS_RT) && (entry_reg.prio <= cmd.item.prio));
            end
            default:
            begin
                ahead = 1'b1;
            end
        endcase
    end

    assign keep      = valid_reg && ahead;
    assign match     = valid_reg && (cmd.head_only || (entry_reg.task_id == cmd.item.task_id));
    assign found_out = found_in || match;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        valid_next = 1'b1;
                        entry_next = cmd.item;
                    end
                    else
                    begin
                        valid_next = prev_valid;
                        entry_next = prev_entry;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (found_in || match)
                begin
                    valid_next = next_valid;
                    entry_next = next_entry;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

### rtl/csq_chain.sv
// Row of waiter cells kept packed from cell 0 in service order.
// Depends on csq_pkg and csq_cell.
`timescale 1ns / 1ps
`default_nettype none

module csq_chain (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csq_pkg::cell_cmd_t            cmd,
    output logic [csq_pkg::WAITERS-1:0]        valid_vec,
    output csq_pkg::entry_t                    head_entry,
    output logic                               found
);
    import csq_pkg::*;

    entry_t entries [WAITERS];
    logic   keeps   [WAITERS];
    logic   founds  [WAITERS];

    genvar g;
    generate
        for (g = 0; g < WAITERS; g++)
        begin : g_cell
            logic   p_valid;
            entry_t p_entry;
            logic   p_keep;
            logic   n_valid;
            entry_t n_entry;
            logic   f_in;

            if (g == 0)
            begin : g_first
                assign p_valid = 1'b0;
                assign p_entry = '0;
                assign p_keep  = 1'b1;
                assign f_in    = 1'b0;
            end
            else
            begin : g_mid
                assign p_valid = valid_vec[g-1];
                assign p_entry = entries[g-1];
                assign p_keep  = keeps[g-1];
                assign f_in    = founds[g-1];
            end

            if (g == WAITERS - 1)
            begin : g_last
                assign n_valid = 1'b0;
                assign n_entry = '0;
            end
            else
            begin : g_inner
                assign n_valid = valid_vec[g+1];
                assign n_entry = entries[g+1];
            end

            csq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_valid (p_valid),
                .prev_entry (p_entry),
                .prev_keep  (p_keep),
                .next_valid (n_valid),
                .next_entry (n_entry),
                .found_in   (f_in),
                .valid      (valid_vec[g]),
                .entry      (entries[g]),
                .keep       (keeps[g]),
                .found_out  (founds[g])
            );
        end
    endgenerate

    assign head_entry = entries[0];
    assign found      = founds[WAITERS-1];

endmodule

`default_nettype wire

### rtl/counting_semaphore_wait_queue.sv
// Top level of the counting semaphore with an ordered waiter queue.
// Depends on csq_pkg and csq_chain (which holds the csq_cell row).
//
// Usage
//   Requests arrive as transfers on the input channel (in_valid/in_ready):
//   func selects wait, post or timeout removal; task_id, task_class,
//   priority_req and timed describe the waiter. Each request except the
//   unused func code yields one result transfer on the output channel
//   (out_valid/out_ready) carrying status, released_task and wake_kind.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data; index 0 loads the count, index 1 sets the post ceiling.
//   cfg_ready is always high; write only while the block is idle.
// Timing
//   A request is registered in the transfer cycle and executed in the next
//   unless the output register is still full: the chain of waiter cells
//   inserts or shifts in that cycle, and the result is loaded into the
//   output register. A new request is taken only once the last one executed.
//   in_ready is high whenever no request is being executed, so a new
//   request is accepted while a result still waits at the output.
// Reset
//   rst_n clears the count to 0, the ceiling to 65535 and empties the queue.
// Stall
//   If the output register is still full, execution waits and the queue
//   does not change until the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_wait_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [csq_pkg::COUNT_W-1:0]       cfg_data,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [csq_pkg::FUNC_W-1:0]        func,
    input  wire logic [csq_pkg::TASK_W-1:0]        task_id,
    input  wire logic [csq_pkg::CLASS_W-1:0]       task_class,
    input  wire logic [csq_pkg::PRIO_W-1:0]        priority_req,
    input  wire logic                              timed,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [csq_pkg::STATUS_W-1:0]           status,
    output logic [csq_pkg::TASK_W-1:0]             released_task,
    output logic                                   wake_kind
);
    import csq_pkg::*;

    ctrl_state_t         state_reg;
    ctrl_state_t         state_next;

    // registered request
    logic [FUNC_W-1:0]   func_reg;
    entry_t              req_reg;
    entry_t              req_next;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  max_reg;
    logic [COUNT_W-1:0]  max_next;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TASK_W-1:0]   rel_reg;
    logic [TASK_W-1:0]   rel_next;
    logic                kind_reg;
    logic                kind_next;

    logic                result_load;
    cell_cmd_t           cmd;
    logic [WAITERS-1:0]  valid_vec;
    entry_t              head_entry;
    logic                found;
    logic                queue_full;
    logic                queue_busy;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign queue_full = valid_vec[WAITERS-1];
    assign queue_busy = valid_vec[0];

    // Capture; an unknown class is queued as normal
    always_comb
    begin
        req_next.task_id = task_id;
        req_next.cls     = ((task_class == CLS_FIFO) || (task_class == CLS_RT)) ?
                           task_class : CLS_NORMAL;
        req_next.prio    = priority_req;
        req_next.timed   = timed;
    end

    // Control and execution of one request
    always_comb
    begin
        state_next    = state_reg;
        result_load   = 1'b0;
        status_next   = status_reg;
        rel_next      = rel_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        max_next      = max_reg;
        cmd.op        = OP_HOLD;
        cmd.head_only = 1'b0;
        cmd.item      = req_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (func_reg == FUNC_NONE)
                begin
                    // no effect and no result
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    state_next  = S_IDLE;
                    result_load = 1'b1;
                    rel_next    = '0;
                    kind_next   = 1'b0;
                    case (func_reg)
                        FUNC_WAIT:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next  = count_reg - 1'b1;
                                status_next = STAT_GRANTED;
                            end
                            else if (queue_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op      = OP_INSERT;
                                status_next = STAT_BLOCKED;
                            end
                        end
                        FUNC_POST:
                        begin
                            if (queue_busy)
                            begin
                                cmd.op        = OP_REMOVE;
                                cmd.head_only = 1'b1;
                                status_next   = STAT_RELEASED;
                                rel_next      = head_entry.task_id;
                                kind_next     = head_entry.timed;
                            end
                            else if (count_reg < max_reg)
                            begin
                                count_next  = count_reg + 1'b1;
                                status_next = STAT_RAISED;
                            end
                            else
                            begin
                                status_next = STAT_OVERFLOW;
                            end
                        end
                        default:
                        begin
                            // timeout: first matching waiter leaves, rest close up
                            cmd.op = OP_REMOVE;
                            if (found)
                            begin
                                status_next = STAT_REMOVED;
                                rel_next    = req_reg.task_id;
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INITIAL_COUNT:
                begin
                    count_next = cfg_data;
                end
                CFG_MAX_COUNT:
                begin
                    max_next = cfg_data;
                end
                default:
                begin
                    max_next = max_reg;
                end
            endcase
        end

        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            req_reg  <= req_next;
        end
        status_reg <= status_next;
        rel_reg    <= rel_next;
        kind_reg   <= kind_next;
    end

    csq_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .valid_vec  (valid_vec),
        .head_entry (head_entry),
        .found      (found)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign released_task = rel_reg;
    assign wake_kind     = kind_reg;

    // Queue stays packed from cell 0
    a_packed : assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("waiter cells not packed");

    // An insert adds exactly one waiter
    a_insert : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INSERT) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("insert did not add one waiter");

    // A release or removal takes exactly one waiter away
    a_remove : assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && ((status_next == STAT_RELEASED) || (status_next == STAT_REMOVED)))
        |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
        else $error("removal did not drop one waiter");

    // A grant takes one unit
    a_grant : assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && (status_next == STAT_GRANTED) && !cfg_valid)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("grant did not decrement count");

    // A request blocks only when no unit is free
    a_no_wait_with_units : assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && (status_next == STAT_BLOCKED)) |-> (count_reg == '0))
        else $error("task blocked while units were free");

endmodule

`default_nettype wire
